// ===== rtl/core/ppe_pkg.sv =====
// shared types, constants and an rgb565 color helper for the palette pixel expander
package ppe_pkg;

    localparam int PAL_DEPTH = 256;
    localparam int PAL_AW = (PAL_DEPTH > 1) ? $clog2(PAL_DEPTH) : 1;
    localparam int MAX_RUN = 512;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W = $clog2(QUEUE_DEPTH);

    localparam logic [1:0] MODE_PAL  = 2'd0;
    localparam logic [1:0] MODE_RUN  = 2'd1;
    localparam logic [1:0] MODE_DATA = 2'd2;

    localparam logic [1:0] FMT_1BPP  = 2'd0;
    localparam logic [1:0] FMT_4BPP  = 2'd1;
    localparam logic [1:0] FMT_8BPP  = 2'd2;
    localparam logic [1:0] FMT_16BPP = 2'd3;

    typedef struct packed {
        logic [1:0]  fmt;
        logic [15:0] word;
        logic [2:0]  start;
        logic [3:0]  count;
    } job_t;

    function automatic logic [15:0] rgb565(input logic [23:0] c);
        return {c[23:19], c[15:10], c[7:3]};
    endfunction

endpackage

// ===== rtl/core/ppe_ram.sv =====
// generic single-write, single-read ram with registered read data
module ppe_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256
) (
    input  logic                                    clk,
    input  logic                                    wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                        wr_data,
    input  logic                                    rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                        rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/core/ppe_front.sv =====
// front end: takes input beats, keeps run state, turns data beats into pixel jobs
module ppe_front (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [1:0]                 mode,
    input  logic [7:0]                 palette_index,
    input  logic [23:0]                palette_color,
    input  logic [1:0]                 pixel_format,
    input  logic [2:0]                 start_offset,
    input  logic [9:0]                 pixel_count,
    input  logic [15:0]                data_word,
    input  logic                       q_full,
    input  logic                       q_empty,
    input  logic                       back_busy,
    output logic                       push,
    output ppe_pkg::job_t              push_job,
    output logic                       pal_we,
    output logic [ppe_pkg::PAL_AW-1:0] pal_waddr,
    output logic [23:0]                pal_wdata
);

    logic [1:0] fmt_reg;
    logic [2:0] offs_reg;
    logic [9:0] left_reg;
    logic       first_reg;

    logic       accept;
    logic [2:0] start;
    logic [3:0] avail;
    logic [3:0] npix;
    logic       idx_ok;

    // palette writes wait until every earlier pixel has read the palette
    assign in_stall = q_full ||
                      ((mode == ppe_pkg::MODE_PAL) && (!q_empty || back_busy));
    assign accept = in_valid && !in_stall;

    assign idx_ok    = ({1'b0, palette_index} < 9'(ppe_pkg::PAL_DEPTH));
    assign pal_we    = accept && (mode == ppe_pkg::MODE_PAL) && idx_ok;
    assign pal_waddr = palette_index[ppe_pkg::PAL_AW-1:0];
    assign pal_wdata = palette_color;

    always_comb
    begin
        start = 3'd0;
        avail = 4'd1;
        unique case (fmt_reg)
            ppe_pkg::FMT_1BPP:
            begin
                start = first_reg ? offs_reg : 3'd0;
                avail = 4'd8 - {1'b0, start};
            end
            ppe_pkg::FMT_4BPP:
            begin
                start = {2'b00, first_reg & offs_reg[0]};
                avail = 4'd2 - {1'b0, start};
            end
            default:
            begin
                start = 3'd0;
                avail = 4'd1;
            end
        endcase
        npix = (left_reg < {6'd0, avail}) ? left_reg[3:0] : avail;
    end

    assign push = accept && (mode == ppe_pkg::MODE_DATA) && (npix != 4'd0);

    always_comb
    begin
        push_job.fmt   = fmt_reg;
        push_job.word  = data_word;
        push_job.start = start;
        push_job.count = npix;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fmt_reg   <= ppe_pkg::FMT_1BPP;
            offs_reg  <= 3'd0;
            left_reg  <= 10'd0;
            first_reg <= 1'b0;
        end
        else if (accept)
        begin
            unique case (mode)
                ppe_pkg::MODE_RUN:
                begin
                    fmt_reg   <= pixel_format;
                    offs_reg  <= start_offset;
                    left_reg  <= ({7'd0, pixel_count} > 17'(ppe_pkg::MAX_RUN)) ?
                                 10'(ppe_pkg::MAX_RUN) : pixel_count;
                    first_reg <= 1'b1;
                end
                ppe_pkg::MODE_DATA:
                begin
                    left_reg  <= left_reg - {6'd0, npix};
                    first_reg <= 1'b0;
                end
                default:
                begin
                end
            endcase
        end
    end

endmodule

// ===== rtl/core/ppe_queue.sv =====
// small job queue between front and back ends
module ppe_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  ppe_pkg::job_t push_job,
    input  logic          pop,
    output ppe_pkg::job_t head,
    output logic          empty,
    output logic          full
);

    ppe_pkg::job_t              slot_reg [ppe_pkg::QUEUE_DEPTH];
    logic [ppe_pkg::QPTR_W-1:0] wr_ptr_reg;
    logic [ppe_pkg::QPTR_W-1:0] rd_ptr_reg;
    logic [ppe_pkg::QPTR_W:0]   cnt_reg;
    logic [ppe_pkg::QPTR_W:0]   cnt_next;

    assign empty = (cnt_reg == '0);
    assign full  = (cnt_reg == (ppe_pkg::QPTR_W + 1)'(ppe_pkg::QUEUE_DEPTH));
    assign head  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            cnt_reg <= cnt_next;
        end
    end

endmodule

// ===== rtl/core/ppe_back.sv =====
// back end: walks each job one pixel a cycle while the output is not stalled, reads the palette, drives output beats
module ppe_back (
    input  logic                       clk,
    input  logic                       rst_n,
    input  ppe_pkg::job_t              head,
    input  logic                       q_empty,
    output logic                       pop,
    output logic                       rd_en,
    output logic [ppe_pkg::PAL_AW-1:0] rd_addr,
    input  logic [23:0]                rd_data,
    output logic                       busy,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [15:0]                pixel_color,
    output logic                       last_pixel
);

    logic          cur_valid_reg;
    ppe_pkg::job_t cur_reg;

    logic          b_valid_reg;
    logic [1:0]    b_fmt_reg;
    logic [15:0]   b_word_reg;
    logic          b_zero_reg;
    logic          b_last_reg;

    logic          out_valid_reg;
    logic [15:0]   pix_reg;
    logic          last_reg;

    logic          out_free;
    logic          b_adv;
    logic          issue;
    logic          last_issue;
    logic [2:0]    bit_sel;
    logic [7:0]    pix_idx;
    logic          idx_ok;
    logic [15:0]   b_color;

    assign out_free   = !out_valid_reg || !out_stall;
    assign b_adv      = b_valid_reg && out_free;
    assign issue      = cur_valid_reg && (!b_valid_reg || out_free);
    assign last_issue = issue && (cur_reg.count == 4'd1);
    assign pop        = !q_empty && (!cur_valid_reg || last_issue);
    assign busy       = cur_valid_reg || b_valid_reg || out_valid_reg;

    // msb-first pixel position inside the byte
    assign bit_sel = 3'd7 - cur_reg.start;

    always_comb
    begin
        unique case (cur_reg.fmt)
            ppe_pkg::FMT_1BPP:
            begin
                pix_idx = {7'd0, cur_reg.word[bit_sel]};
            end
            ppe_pkg::FMT_4BPP:
            begin
                pix_idx = cur_reg.start[0] ? {4'd0, cur_reg.word[3:0]} :
                                             {4'd0, cur_reg.word[7:4]};
            end
            default:
            begin
                pix_idx = cur_reg.word[7:0];
            end
        endcase
    end

    assign idx_ok  = ({1'b0, pix_idx} < 9'(ppe_pkg::PAL_DEPTH));
    assign rd_en   = issue;
    assign rd_addr = pix_idx[ppe_pkg::PAL_AW-1:0];

    always_comb
    begin
        unique case (b_fmt_reg) inside
            ppe_pkg::FMT_1BPP:
            begin
                b_color = b_zero_reg ? 16'd0 : rd_data[15:0];
            end
            ppe_pkg::FMT_4BPP, ppe_pkg::FMT_8BPP:
            begin
                b_color = b_zero_reg ? 16'd0 : ppe_pkg::rgb565(rd_data);
            end
            default:
            begin
                b_color = b_word_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            b_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                cur_valid_reg <= 1'b1;
            end
            else if (last_issue)
            begin
                cur_valid_reg <= 1'b0;
            end

            if (issue)
            begin
                b_valid_reg <= 1'b1;
            end
            else if (b_adv)
            begin
                b_valid_reg <= 1'b0;
            end

            if (b_adv)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cur_reg <= head;
        end
        else if (issue)
        begin
            cur_reg.start <= cur_reg.start + 3'd1;
            cur_reg.count <= cur_reg.count - 4'd1;
        end

        if (issue)
        begin
            b_fmt_reg  <= cur_reg.fmt;
            b_word_reg <= cur_reg.word;
            b_zero_reg <= !idx_ok;
            b_last_reg <= (cur_reg.count == 4'd1);
        end

        if (b_adv)
        begin
            pix_reg  <= b_color;
            last_reg <= b_last_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign pixel_color = pix_reg;
    assign last_pixel  = last_reg;

endmodule

// ===== rtl/core/palette_pixel_expander_rgb565.sv =====
// palette pixel expander top: front end, job queue, back end and palette ram
// the first pixel of a data beat passes the job queue, current job, palette read and output register
// throughput: one pixel per cycle from the back end while out_stall is low; a data beat gives 1 to 8 pixels
// run and data beats are taken every cycle while the 4-entry job queue has room
// palette writes wait until all queued pixels are out
// reset clears run state, queue and pipeline valids; palette ram is not cleared
module palette_pixel_expander_rgb565 (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  mode,
    input  logic [7:0]  palette_index,
    input  logic [23:0] palette_color,
    input  logic [1:0]  pixel_format,
    input  logic [2:0]  start_offset,
    input  logic [9:0]  pixel_count,
    input  logic [15:0] data_word,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [15:0] pixel_color,
    output logic        last_pixel
);

    logic                       q_full;
    logic                       q_empty;
    logic                       q_push;
    logic                       q_pop;
    ppe_pkg::job_t              q_in;
    ppe_pkg::job_t              q_head;
    logic                       back_busy;
    logic                       pal_we;
    logic [ppe_pkg::PAL_AW-1:0] pal_waddr;
    logic [23:0]                pal_wdata;
    logic                       pal_re;
    logic [ppe_pkg::PAL_AW-1:0] pal_raddr;
    logic [23:0]                pal_rdata;

    ppe_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .mode          (mode),
        .palette_index (palette_index),
        .palette_color (palette_color),
        .pixel_format  (pixel_format),
        .start_offset  (start_offset),
        .pixel_count   (pixel_count),
        .data_word     (data_word),
        .q_full        (q_full),
        .q_empty       (q_empty),
        .back_busy     (back_busy),
        .push          (q_push),
        .push_job      (q_in),
        .pal_we        (pal_we),
        .pal_waddr     (pal_waddr),
        .pal_wdata     (pal_wdata)
    );

    ppe_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_job (q_in),
        .pop      (q_pop),
        .head     (q_head),
        .empty    (q_empty),
        .full     (q_full)
    );

    ppe_ram #(
        .WIDTH (24),
        .DEPTH (ppe_pkg::PAL_DEPTH)
    ) u_palette (
        .clk     (clk),
        .wr_en   (pal_we),
        .wr_addr (pal_waddr),
        .wr_data (pal_wdata),
        .rd_en   (pal_re),
        .rd_addr (pal_raddr),
        .rd_data (pal_rdata)
    );

    ppe_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (q_head),
        .q_empty     (q_empty),
        .pop         (q_pop),
        .rd_en       (pal_re),
        .rd_addr     (pal_raddr),
        .rd_data     (pal_rdata),
        .busy        (back_busy),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .pixel_color (pixel_color),
        .last_pixel  (last_pixel)
    );

`ifndef SYNTHESIS
    // a palette write must never overtake pixels still waiting to read it
    a_pal_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        pal_we |-> (q_empty && !back_busy))
        else $error("palette write while pixels pending");

    // no push into a full queue
    a_queue_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_full |-> !q_push)
        else $error("job queue overflow");

    // palette ram is never written and read in the same cycle
    a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        pal_we |-> !pal_re)
        else $error("palette read and write overlap");

    // no pop from an empty queue
    a_queue_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_empty |-> !q_pop)
        else $error("job queue underflow");
`endif

endmodule
